FILE: rtl/generalized_suffix_automaton_defines.svh
// Assertion macros for the generalized suffix automaton.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef GENERALIZED_SUFFIX_AUTOMATON_DEFINES_SVH
`define GENERALIZED_SUFFIX_AUTOMATON_DEFINES_SVH

// Same-cycle implication.
`define GSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gsa_pkg.sv
// Shared constants, types and helpers for the generalized suffix automaton.
// No dependencies.
`timescale 1ns / 1ps

package gsa_pkg;
  localparam int NODES    = 4096;
  localparam int ALPHABET = 26;
  localparam int NODE_W   = 12;
  localparam int SYM_W    = 5;
  localparam int LEN_W    = 12;
  localparam int OP_W     = 2;
  localparam int TDEPTH   = NODES * ALPHABET;
  localparam int TADDR_W  = $clog2(TDEPTH);
  localparam int IDX_W    = $clog2(ALPHABET + 1);
  localparam int CNT_W    = NODE_W + 1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TADDR_W-1:0] taddr_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_EXTEND = 2'd1,
    OP_STEP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam node_t NULL_NODE = node_t'(0);
  localparam node_t ROOT_NODE = node_t'(1);

  typedef struct packed {
    logic  mark;
    len_t  len;
    node_t link;
  } node_word_t;

  localparam int NWORD_W = $bits(node_word_t);

  // Row-major edge address: node * ALPHABET + symbol.
  function automatic taddr_t taddr(input node_t n, input idx_t k);
    return TADDR_W'(n) * TADDR_W'(ALPHABET) + TADDR_W'(k);
  endfunction
endpackage

FILE: rtl/gsa_ifs.sv
// Request and response channel interfaces for the generalized suffix automaton.
// Depends on gsa_pkg.
`timescale 1ns / 1ps

interface gsa_req_if;
  import gsa_pkg::*;
  logic  valid;
  logic  ready;
  logic [OP_W-1:0] op;
  sym_t  symbol;
  node_t from_node;
  logic  mark_end;
  modport source(output valid, op, symbol, from_node, mark_end, input ready);
  modport sink(input valid, op, symbol, from_node, mark_end, output ready);
endinterface

interface gsa_rsp_if;
  import gsa_pkg::*;
  logic  valid;
  logic  ready;
  node_t node;
  logic  is_end;
  logic  found;
  logic  full_res;
  modport source(output valid, node, is_end, found, full_res, input ready);
  modport sink(input valid, node, is_end, found, full_res, output ready);
endinterface

FILE: rtl/generalized_suffix_automaton.sv
// Generalized suffix automaton builder. Edges live in one RAM (NODES*ALPHABET
// rows of 12 bits), and suffix link, length and end mark per node in a second
// RAM; both have one read and one write port with a registered read. Each op
// yields one response beat. Clear wipes the root's edge row. Extend ends after
// the edge read and a length check when the edge already exists with the right
// length. If the edge is missing, it wipes the new node's row, writes the first
// edge and walks the suffix links; a clone, made when a target has the wrong
// length, adds a compare, an allocate, a row copy and the redirected edge
// writes. A new request is taken once the previous op has finished and its
// response can be handed on.
`timescale 1ns / 1ps
`include "generalized_suffix_automaton_defines.svh"

module generalized_suffix_automaton (
  input logic clk,
  input logic rst,
  gsa_req_if.sink   req,
  gsa_rsp_if.source rsp
);
  import gsa_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_CLR     = 14'b00000000000010,
    ST_S_RD    = 14'b00000000000100,
    ST_S_MK    = 14'b00000000001000,
    ST_X_RD    = 14'b00000000010000,
    ST_X_Q     = 14'b00000000100000,
    ST_WIPE    = 14'b00000001000000,
    ST_WALK    = 14'b00000010000000,
    ST_WALK_RD = 14'b00000100000000,
    ST_WALK_Q  = 14'b00001000000000,
    ST_SPLIT   = 14'b00010000000000,
    ST_COPY    = 14'b00100000000000,
    ST_REDIR   = 14'b01000000000000,
    ST_REDIR_RD = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  node_t cnt, cnt_next;
  node_t p, p_next, q, q_next, np, np_next, nq, nq_next, plink, plink_next;
  sym_t  c, c_next;
  len_t  lenp, lenp_next, np_len, np_len_next;
  logic  mark, mark_next, clone_mark, clone_mark_next, split_new, split_new_next;
  node_word_t qword, qword_next;
  idx_t  idx, idx_next;

  logic  ovalid, ovalid_next, oend, oend_next, ofound, ofound_next, ofull, ofull_next;
  node_t onode, onode_next;

  // edge RAM
  logic t_we;
  taddr_t t_waddr, t_raddr;
  node_t t_wdata, t_rdata;
  // node RAM
  logic n_we;
  node_t n_waddr, n_raddr;
  node_word_t n_wdata, n_rdata;
  logic [NWORD_W-1:0] n_rraw;

  logic fin, redir_end, live, room, accept;
  node_t f_node;
  logic f_end, f_found, f_full;

  gsa_ram #(.WIDTH(NODE_W), .DEPTH(TDEPTH)) u_edges (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  gsa_ram #(.WIDTH(NWORD_W), .DEPTH(NODES)) u_nodes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rraw)
  );
  assign n_rdata = node_word_t'(n_rraw);

  assign req.ready = (state == ST_IDLE) && (!ovalid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign live = (req.from_node != NULL_NODE) && (req.from_node <= cnt) &&
                (req.symbol < SYM_W'(ALPHABET));
  assign room = (CNT_W'(cnt) + CNT_W'(2)) < CNT_W'(NODES);

  assign rsp.valid    = ovalid;
  assign rsp.node     = onode;
  assign rsp.is_end   = oend;
  assign rsp.found    = ofound;
  assign rsp.full_res = ofull;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    p_next = p; q_next = q; np_next = np; nq_next = nq; plink_next = plink;
    c_next = c; lenp_next = lenp; np_len_next = np_len; mark_next = mark;
    clone_mark_next = clone_mark; split_new_next = split_new;
    qword_next = qword; idx_next = idx;
    t_we = 1'b0; t_waddr = taddr(p, IDX_W'(c)); t_wdata = NULL_NODE;
    t_raddr = taddr(p, IDX_W'(c));
    n_we = 1'b0; n_waddr = p; n_wdata = '0; n_raddr = p;
    fin = 1'b0; redir_end = 1'b0;
    f_node = NULL_NODE; f_end = 1'b0; f_found = 1'b0; f_full = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          p_next = req.from_node;
          c_next = req.symbol;
          mark_next = req.mark_end;
          t_raddr = taddr(req.from_node, IDX_W'(req.symbol));
          n_raddr = req.from_node;
          case (op_t'(req.op))
            OP_CLEAR: begin
              n_we = 1'b1; n_waddr = ROOT_NODE; n_wdata = '0;
              cnt_next = ROOT_NODE;
              idx_next = '0;
              state_next = ST_CLR;
            end
            OP_EXTEND: begin
              if (!room) begin
                fin = 1'b1; f_full = 1'b1;
              end else if (!live) begin
                fin = 1'b1;
              end else begin
                state_next = ST_X_RD;
              end
            end
            OP_STEP: begin
              if (!live) begin
                fin = 1'b1;
              end else begin
                state_next = ST_S_RD;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end

      ST_CLR: begin
        t_we = 1'b1; t_waddr = taddr(ROOT_NODE, idx); t_wdata = NULL_NODE;
        idx_next = idx + idx_t'(1);
        if (idx == IDX_W'(ALPHABET - 1)) begin
          fin = 1'b1; f_node = ROOT_NODE;
          state_next = ST_IDLE;
        end
      end

      ST_S_RD: begin
        q_next = t_rdata;
        n_raddr = t_rdata;
        if (t_rdata == NULL_NODE) begin
          fin = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_S_MK;
        end
      end

      ST_S_MK: begin
        fin = 1'b1; f_node = q; f_end = n_rdata.mark; f_found = 1'b1;
        state_next = ST_IDLE;
      end

      ST_X_RD: begin
        q_next = t_rdata;
        lenp_next = n_rdata.len;
        plink_next = n_rdata.link;
        n_raddr = t_rdata;
        if (t_rdata != NULL_NODE) begin
          state_next = ST_X_Q;
        end else begin
          np_next = cnt + node_t'(1);
          cnt_next = cnt + node_t'(1);
          np_len_next = n_rdata.len + len_t'(1);
          idx_next = '0;
          state_next = ST_WIPE;
        end
      end

      ST_X_Q: begin
        qword_next = n_rdata;
        if (n_rdata.len == lenp + len_t'(1)) begin
          fin = 1'b1; f_node = q; f_end = n_rdata.mark; f_found = 1'b1;
          state_next = ST_IDLE;
        end else begin
          clone_mark_next = mark;
          split_new_next = 1'b0;
          state_next = ST_SPLIT;
        end
      end

      ST_WIPE: begin
        t_we = 1'b1; t_waddr = taddr(np, idx); t_wdata = NULL_NODE;
        idx_next = idx + idx_t'(1);
        if (idx == IDX_W'(ALPHABET - 1)) begin
          state_next = ST_WALK;
        end
      end

      ST_WALK: begin
        t_we = 1'b1; t_waddr = taddr(p, IDX_W'(c)); t_wdata = np;
        p_next = plink;
        t_raddr = taddr(plink, IDX_W'(c));
        n_raddr = plink;
        if (plink == NULL_NODE) begin
          n_we = 1'b1; n_waddr = np; n_wdata = '{mark: mark, len: np_len, link: ROOT_NODE};
          fin = 1'b1; f_node = np; f_end = mark; f_found = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_WALK_RD;
        end
      end

      ST_WALK_RD: begin
        lenp_next = n_rdata.len;
        plink_next = n_rdata.link;
        q_next = t_rdata;
        n_raddr = t_rdata;
        if (t_rdata == NULL_NODE) begin
          state_next = ST_WALK;
        end else begin
          state_next = ST_WALK_Q;
        end
      end

      ST_WALK_Q: begin
        qword_next = n_rdata;
        if (n_rdata.len == lenp + len_t'(1)) begin
          n_we = 1'b1; n_waddr = np; n_wdata = '{mark: mark, len: np_len, link: q};
          fin = 1'b1; f_node = np; f_end = mark; f_found = 1'b1;
          state_next = ST_IDLE;
        end else begin
          clone_mark_next = 1'b0;
          split_new_next = 1'b1;
          state_next = ST_SPLIT;
        end
      end

      ST_SPLIT: begin
        nq_next = cnt + node_t'(1);
        cnt_next = cnt + node_t'(1);
        n_we = 1'b1; n_waddr = cnt + node_t'(1);
        n_wdata = '{mark: clone_mark, len: lenp + len_t'(1), link: qword.link};
        t_raddr = taddr(q, '0);
        idx_next = idx_t'(1);
        state_next = ST_COPY;
      end

      // read edge idx of q while writing edge idx-1 of the clone
      ST_COPY: begin
        t_we = 1'b1; t_waddr = taddr(nq, idx - idx_t'(1)); t_wdata = t_rdata;
        t_raddr = taddr(q, idx);
        if (idx == IDX_W'(ALPHABET)) begin
          n_we = 1'b1; n_waddr = q;
          n_wdata = '{mark: qword.mark, len: qword.len, link: nq};
          state_next = ST_REDIR;
        end else begin
          idx_next = idx + idx_t'(1);
        end
      end

      ST_REDIR: begin
        t_we = 1'b1; t_waddr = taddr(p, IDX_W'(c)); t_wdata = nq;
        p_next = plink;
        t_raddr = taddr(plink, IDX_W'(c));
        n_raddr = plink;
        if (plink == NULL_NODE) begin
          redir_end = 1'b1;
        end else begin
          state_next = ST_REDIR_RD;
        end
      end

      ST_REDIR_RD: begin
        lenp_next = n_rdata.len;
        plink_next = n_rdata.link;
        if (t_rdata == q) begin
          state_next = ST_REDIR;
        end else begin
          redir_end = 1'b1;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // clone done: in the normal case the new node links to the clone
    if (redir_end) begin
      fin = 1'b1; f_end = mark; f_found = 1'b1;
      state_next = ST_IDLE;
      if (split_new) begin
        n_we = 1'b1; n_waddr = np; n_wdata = '{mark: mark, len: np_len, link: nq};
        f_node = np;
      end else begin
        f_node = nq;
      end
    end
  end

  always_comb begin
    ovalid_next = ovalid;
    onode_next = onode; oend_next = oend; ofound_next = ofound; ofull_next = ofull;
    if (fin) begin
      ovalid_next = 1'b1;
      onode_next = f_node; oend_next = f_end; ofound_next = f_found; ofull_next = f_full;
    end else if (rsp.ready) begin
      ovalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= ROOT_NODE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      ovalid <= ovalid_next;
    end
    p <= p_next; q <= q_next; np <= np_next; nq <= nq_next; plink <= plink_next;
    c <= c_next; lenp <= lenp_next; np_len <= np_len_next; mark <= mark_next;
    clone_mark <= clone_mark_next; split_new <= split_new_next;
    qword <= qword_next; idx <= idx_next;
    onode <= onode_next; oend <= oend_next; ofound <= ofound_next; ofull <= ofull_next;
  end

  `GSA_ASSERT_NOW(a_busy_no_rsp, state != ST_IDLE, !ovalid, "response pending while busy")
  `GSA_ASSERT_NOW(a_cnt_nonzero, 1'b1, cnt != NULL_NODE, "node count lost the root")
  `GSA_ASSERT_NEXT(a_split_alloc, state == ST_SPLIT, cnt == $past(cnt) + node_t'(1), "clone not allocated")
  `GSA_ASSERT_NOW(a_walk_live, state == ST_WALK || state == ST_REDIR, p != NULL_NODE, "edge write on null node")
endmodule

FILE: rtl/gsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
